>>> hw/rtl/gcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared constants and the CORDIC arctangent table for the great-circle
// distance pipeline.
// ----------------------------------------------------------------------------
package gcd_pkg;

  localparam int ANGLE_FRAC_BITS = 28;
  localparam int CORDIC_STAGES   = 24;
  localparam int STAGE_CAP       = 32;

  // cordic datapath width, values in q2.30 plus headroom
  localparam int CORDIC_W = 34;
  // restoring square root input width (even)
  localparam int SQRT_IN_W = 62;

  localparam logic [33:0] GAIN_Q30         = 34'd652032874;
  localparam logic [33:0] ONE_Q30          = 34'd1073741824;
  localparam logic [31:0] TURN_PER_RAD_Q32 = 32'd683565276;
  localparam logic [31:0] TWO_PI_Q28       = 32'd1686629713;
  localparam logic [33:0] DIST_MAX         = 34'h3_FFFF_FFFF;

  // atan(2^-i) in turns * 2^32
  function automatic logic [31:0] atan_turns(input int unsigned idx);
    logic [31:0] val;
    case (idx)
      0:  val = 32'd536870912;
      1:  val = 32'd316933406;
      2:  val = 32'd167458908;
      3:  val = 32'd85004756;
      4:  val = 32'd42667331;
      5:  val = 32'd21354465;
      6:  val = 32'd10679838;
      7:  val = 32'd5340245;
      8:  val = 32'd2670163;
      9:  val = 32'd1335087;
      10: val = 32'd667544;
      11: val = 32'd333772;
      12: val = 32'd166886;
      13: val = 32'd83443;
      14: val = 32'd41722;
      15: val = 32'd20861;
      16: val = 32'd10430;
      17: val = 32'd5215;
      18: val = 32'd2608;
      19: val = 32'd1304;
      20: val = 32'd652;
      21: val = 32'd326;
      22: val = 32'd163;
      23: val = 32'd81;
      24: val = 32'd41;
      25: val = 32'd20;
      26: val = 32'd10;
      27: val = 32'd5;
      28: val = 32'd3;
      29: val = 32'd1;
      30: val = 32'd1;
      default: val = 32'd0;
    endcase
    return val;
  endfunction

endpackage

>>> hw/rtl/gcd_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_cordic
// Pipelined CORDIC, one micro-rotation per register stage, several lanes
// in lockstep. Rotation mode drives z to zero, vectoring mode drives y.
// ----------------------------------------------------------------------------
module gcd_cordic #(
  parameter int STAGES = gcd_pkg::CORDIC_STAGES,
  parameter bit VECTOR = 1'b0,
  parameter int LANES  = 1,
  parameter int W      = gcd_pkg::CORDIC_W,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [W-1:0] in_x [LANES],
  input  logic signed [W-1:0] in_y [LANES],
  input  logic signed [W-1:0] in_z [LANES],
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_valid,
  output logic signed [W-1:0] out_x [LANES],
  output logic signed [W-1:0] out_y [LANES],
  output logic signed [W-1:0] out_z [LANES],
  output logic [SIDE_W-1:0]   out_side
);

  logic signed [W-1:0] x_r [STAGES][LANES];
  logic signed [W-1:0] y_r [STAGES][LANES];
  logic signed [W-1:0] z_r [STAGES][LANES];
  logic [SIDE_W-1:0]   side_r  [STAGES];
  logic                valid_r [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic              valid_cur;
    logic [SIDE_W-1:0] side_cur;

    if (i == 0) begin : g_first
      assign valid_cur = in_valid;
      assign side_cur  = in_side;
    end else begin : g_next
      assign valid_cur = valid_r[i-1];
      assign side_cur  = side_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i] <= 1'b0;
      end else if (en) begin
        valid_r[i] <= valid_cur;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[i] <= side_cur;
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic signed [W-1:0] x_cur, y_cur, z_cur;
      logic signed [W-1:0] x_nxt, y_nxt, z_nxt;
      logic signed [W-1:0] x_sh, y_sh, ang;
      logic                dir_up;

      if (i == 0) begin : g_first
        assign x_cur = in_x[l];
        assign y_cur = in_y[l];
        assign z_cur = in_z[l];
      end else begin : g_next
        assign x_cur = x_r[i-1][l];
        assign y_cur = y_r[i-1][l];
        assign z_cur = z_r[i-1][l];
      end

      always_comb begin
        x_sh = x_cur >>> i;
        y_sh = y_cur >>> i;
        ang  = signed'(W'(gcd_pkg::atan_turns(i)));
        // rotation follows the sign of z, vectoring pulls y toward zero
        if (VECTOR) begin
          dir_up = y_cur[W-1] || (y_cur == '0);
        end else begin
          dir_up = !z_cur[W-1];
        end
        if (dir_up) begin
          x_nxt = x_cur - y_sh;
          y_nxt = y_cur + x_sh;
          z_nxt = z_cur - ang;
        end else begin
          x_nxt = x_cur + y_sh;
          y_nxt = y_cur - x_sh;
          z_nxt = z_cur + ang;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          x_r[i][l] <= x_nxt;
          y_r[i][l] <= y_nxt;
          z_r[i][l] <= z_nxt;
        end
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign out_x[l] = x_r[STAGES-1][l];
    assign out_y[l] = y_r[STAGES-1][l];
    assign out_z[l] = z_r[STAGES-1][l];
  end

  assign out_valid = valid_r[STAGES-1];
  assign out_side  = side_r[STAGES-1];

endmodule

>>> hw/rtl/gcd_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_sqrt
// Pipelined restoring integer square root (floor), one result bit per
// register stage, with a sideband that travels alongside.
// ----------------------------------------------------------------------------
module gcd_sqrt #(
  parameter int IN_W   = gcd_pkg::SQRT_IN_W,
  parameter int SIDE_W = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [IN_W-1:0]      in_value,
  input  logic [SIDE_W-1:0]    in_side,
  output logic                 out_valid,
  output logic [IN_W/2-1:0]    out_root,
  output logic [SIDE_W-1:0]    out_side
);

  localparam int ITER = IN_W / 2;

  logic [IN_W-1:0]   v_r     [ITER];
  logic [IN_W-1:0]   res_r   [ITER];
  logic [SIDE_W-1:0] side_r  [ITER];
  logic              valid_r [ITER];

  for (genvar k = 0; k < ITER; k++) begin : g_stage
    localparam logic [IN_W:0] BIT = (IN_W+1)'(1) << (IN_W - 2 - 2 * k);
    logic [IN_W-1:0]   v_cur, res_cur, v_nxt, res_nxt;
    logic [IN_W:0]     trial;
    logic              valid_cur;
    logic [SIDE_W-1:0] side_cur;

    if (k == 0) begin : g_first
      assign v_cur     = in_value;
      assign res_cur   = '0;
      assign valid_cur = in_valid;
      assign side_cur  = in_side;
    end else begin : g_next
      assign v_cur     = v_r[k-1];
      assign res_cur   = res_r[k-1];
      assign valid_cur = valid_r[k-1];
      assign side_cur  = side_r[k-1];
    end

    always_comb begin
      trial = {1'b0, res_cur} + BIT;
      if ({1'b0, v_cur} >= trial) begin
        v_nxt   = IN_W'({1'b0, v_cur} - trial);
        res_nxt = IN_W'({1'b0, res_cur >> 1} + BIT);
      end else begin
        v_nxt   = v_cur;
        res_nxt = res_cur >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (en) begin
        valid_r[k] <= valid_cur;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v_r[k]    <= v_nxt;
        res_r[k]  <= res_nxt;
        side_r[k] <= side_cur;
      end
    end
  end

  assign out_valid = valid_r[ITER-1];
  assign out_root  = res_r[ITER-1][IN_W/2-1:0];
  assign out_side  = side_r[ITER-1];

endmodule

>>> hw/rtl/great_circle_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// great_circle_distance
// Haversine great-circle distance between two points, fully pipelined.
// ----------------------------------------------------------------------------
// Usage: each input item carries two radii (q16.16), two polar angles and
// two azimuths (signed radians, ANGLE_FRAC_BITS fraction bits) and a
// unit-sphere flag. Each item yields one result item: the distance in
// q18.16 (arc length, or central angle when unit_sphere is set) and a
// radius mismatch flag, which forces the distance to zero.
// Both channels use valid/ready. One item enters per cycle while the
// receiver does not stall; the pipeline holds 75 + 2 * CORDIC_STAGES
// register stages plus the output register. The depth is set by the two
// CORDIC pipelines (rotation and vectoring) and the two 31-stage square
// roots. When the receiver stalls with a result waiting, the whole pipeline
// holds and in_ready drops; nothing is lost or repeated, and in_ready rises
// again in the cycle the result is taken.
// Reset (synchronous, active low) clears all valid bits; no items are
// in flight afterwards.
// ----------------------------------------------------------------------------
module great_circle_distance #(
  parameter int ANGLE_FRAC_BITS = gcd_pkg::ANGLE_FRAC_BITS,
  parameter int CORDIC_STAGES   = gcd_pkg::CORDIC_STAGES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        in_first_radius,
  input  logic [31:0]        in_second_radius,
  input  logic signed [31:0] in_first_theta,
  input  logic signed [31:0] in_first_phi,
  input  logic signed [31:0] in_second_theta,
  input  logic signed [31:0] in_second_phi,
  input  logic               in_unit_sphere,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [33:0]        out_distance,
  output logic               out_radius_mismatch
);

  localparam int CW     = gcd_pkg::CORDIC_W;
  localparam int SQW    = gcd_pkg::SQRT_IN_W;
  localparam int RW     = SQW / 2;
  localparam int SIDE_W = 34;
  localparam int NST    = (CORDIC_STAGES > gcd_pkg::STAGE_CAP) ?
                          gcd_pkg::STAGE_CAP : CORDIC_STAGES;

  logic en;
  logic out_valid_r;
  logic [33:0] out_distance_r;
  logic out_mismatch_r;

  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign out_valid = out_valid_r;
  assign out_distance        = out_distance_r;
  assign out_radius_mismatch = out_mismatch_r;

  // ---------------- stage 1: input register
  logic               s1_v_r;
  logic [31:0]        s1_r1_r, s1_r2_r;
  logic signed [31:0] s1_t1_r, s1_p1_r, s1_t2_r, s1_p2_r;
  logic               s1_unit_r;

  // ---------------- stage 2: differences and radius check
  logic               s2_v_r;
  logic signed [32:0] s2_ang_r [4];
  logic [31:0]        s2_r1_r;
  logic               s2_unit_r, s2_mism_r;
  logic [31:0]        rdiff;
  logic [38:0]        rdiff100;
  logic               mism_nxt;

  always_comb begin
    rdiff    = (s1_r1_r > s1_r2_r) ? (s1_r1_r - s1_r2_r) : (s1_r2_r - s1_r1_r);
    rdiff100 = 39'(rdiff) * 39'd100;
    mism_nxt = !s1_unit_r && (rdiff100 > 39'(s1_r1_r));
  end

  // ---------------- stage 3: phase in turns
  logic               s3_v_r;
  logic [31:0]        s3_ph_r [4];
  logic [31:0]        s3_r1_r;
  logic               s3_unit_r, s3_mism_r;
  logic [31:0]        ph_nxt [4];

  always_comb begin
    logic signed [63:0] prod;
    logic signed [63:0] sum;
    for (int k = 0; k < 4; k++) begin
      prod = 64'(s2_ang_r[k]) * signed'(64'(gcd_pkg::TURN_PER_RAD_Q32));
      sum  = prod + (64'sd1 <<< (ANGLE_FRAC_BITS - 1));
      ph_nxt[k] = sum[ANGLE_FRAC_BITS+31:ANGLE_FRAC_BITS];
    end
  end

  // ---------------- stage 4: quadrant split
  logic               s4_v_r;
  logic [1:0]         s4_q_r [4];
  logic signed [CW-1:0] s4_z_r [4];
  logic [31:0]        s4_r1_r;
  logic               s4_unit_r, s4_mism_r;
  logic [1:0]         q_nxt [4];
  logic signed [CW-1:0] z_nxt [4];

  always_comb begin
    logic [31:0] shifted;
    logic [31:0] resid;
    for (int k = 0; k < 4; k++) begin
      shifted  = s3_ph_r[k] + 32'h2000_0000;
      q_nxt[k] = shifted[31:30];
      resid    = s3_ph_r[k] - {shifted[31:30], 30'd0};
      z_nxt[k] = CW'(signed'(resid));
    end
  end

  // ---------------- rotation cordic, four lanes
  logic signed [CW-1:0] rot_x_in [4];
  logic signed [CW-1:0] rot_y_in [4];
  logic signed [CW-1:0] rot_x [4];
  logic signed [CW-1:0] rot_y [4];
  logic [SIDE_W+7:0]    rot_side;
  logic                 rot_v;

  for (genvar k = 0; k < 4; k++) begin : g_rot_in
    assign rot_x_in[k] = signed'(gcd_pkg::GAIN_Q30);
    assign rot_y_in[k] = '0;
  end

  gcd_cordic #(
    .STAGES (NST),
    .VECTOR (1'b0),
    .LANES  (4),
    .W      (CW),
    .SIDE_W (SIDE_W + 8)
  ) u_rot (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s4_v_r),
    .in_x      (rot_x_in),
    .in_y      (rot_y_in),
    .in_z      (s4_z_r),
    .in_side   ({s4_q_r[3], s4_q_r[2], s4_q_r[1], s4_q_r[0],
                 s4_r1_r, s4_unit_r, s4_mism_r}),
    .out_valid (rot_v),
    .out_x     (rot_x),
    .out_y     (rot_y),
    .out_z     (),
    .out_side  (rot_side)
  );

  // ---------------- stage 5: quadrant fold, haversines
  logic               s5_v_r;
  logic [31:0]        s5_hvt_r, s5_hvp_r;
  logic signed [31:0] s5_s1_r, s5_s2_r;
  logic [SIDE_W-1:0]  s5_side_r;
  logic signed [CW-1:0] cos_v [4];
  logic signed [CW-1:0] sin_v [4];
  logic [31:0]        hv_nxt [2];

  always_comb begin
    logic [1:0] q;
    logic signed [CW:0] diff;
    for (int k = 0; k < 4; k++) begin
      q = rot_side[SIDE_W + 2*k +: 2];
      case (q)
        2'd0: begin
          cos_v[k] = rot_x[k];
          sin_v[k] = rot_y[k];
        end
        2'd1: begin
          cos_v[k] = -rot_y[k];
          sin_v[k] = rot_x[k];
        end
        2'd2: begin
          cos_v[k] = -rot_x[k];
          sin_v[k] = -rot_y[k];
        end
        default: begin
          cos_v[k] = rot_y[k];
          sin_v[k] = -rot_x[k];
        end
      endcase
    end
    for (int k = 0; k < 2; k++) begin
      diff = signed'({1'b0, gcd_pkg::ONE_Q30}) - (CW+1)'(cos_v[k]);
      if (diff[CW]) begin
        hv_nxt[k] = '0;
      end else begin
        hv_nxt[k] = 32'(diff >>> 1);
      end
    end
  end

  // ---------------- stage 6: sin product
  logic               s6_v_r;
  logic signed [CW-1:0] s6_prod_r;
  logic [31:0]        s6_hvt_r, s6_hvp_r;
  logic [SIDE_W-1:0]  s6_side_r;
  logic signed [63:0] sprod;

  assign sprod = 64'(s5_s1_r) * 64'(s5_s2_r);

  // ---------------- stage 7: times haversine of azimuth difference
  logic               s7_v_r;
  logic signed [CW-1:0] s7_m_r;
  logic [31:0]        s7_hvt_r;
  logic [SIDE_W-1:0]  s7_side_r;
  logic signed [67:0] mprod;

  assign mprod = 68'(s6_prod_r) * 68'(signed'({1'b0, s6_hvp_r}));

  // ---------------- stage 8: h, clamped to [0, 1], into q60
  logic               s8_v_r;
  logic [SQW-1:0]     s8_val_r;
  logic [SIDE_W-1:0]  s8_side_r;
  logic [SQW-1:0]     hval_nxt;

  always_comb begin
    logic signed [CW:0] h;
    h = signed'((CW+1)'(s7_hvt_r)) + (CW+1)'(s7_m_r);
    if (h[CW]) begin
      hval_nxt = '0;
    end else if (h > signed'((CW+1)'(gcd_pkg::ONE_Q30))) begin
      hval_nxt = SQW'(gcd_pkg::ONE_Q30) << 30;
    end else begin
      hval_nxt = SQW'(h[30:0]) << 30;
    end
  end

  // ---------------- square root of h
  logic               sq1_v;
  logic [RW-1:0]      sq1_root;
  logic [SIDE_W-1:0]  sq1_side;

  gcd_sqrt #(
    .IN_W   (SQW),
    .SIDE_W (SIDE_W)
  ) u_sqrt_h (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s8_v_r),
    .in_value  (s8_val_r),
    .in_side   (s8_side_r),
    .out_valid (sq1_v),
    .out_root  (sq1_root),
    .out_side  (sq1_side)
  );

  // ---------------- stages 9 and 10: 1 - root^2
  logic               s9_v_r, s10_v_r;
  logic [SQW-1:0]     s9_sq_r, s10_val_r;
  logic [RW-1:0]      s9_root_r, s10_root_r;
  logic [SIDE_W-1:0]  s9_side_r, s10_side_r;

  // ---------------- cosine side of the half angle
  logic               sq2_v;
  logic [RW-1:0]      sq2_root;
  logic [RW+SIDE_W-1:0] sq2_side;

  gcd_sqrt #(
    .IN_W   (SQW),
    .SIDE_W (RW + SIDE_W)
  ) u_sqrt_c (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s10_v_r),
    .in_value  (s10_val_r),
    .in_side   ({s10_root_r, s10_side_r}),
    .out_valid (sq2_v),
    .out_root  (sq2_root),
    .out_side  (sq2_side)
  );

  // ---------------- vectoring cordic: half angle in turns
  logic signed [CW-1:0] vec_x_in [1];
  logic signed [CW-1:0] vec_y_in [1];
  logic signed [CW-1:0] vec_z_in [1];
  logic signed [CW-1:0] vec_z [1];
  logic [SIDE_W-1:0]    vec_side;
  logic                 vec_v;

  assign vec_x_in[0] = signed'(CW'(sq2_root));
  assign vec_y_in[0] = signed'(CW'(sq2_side[RW+SIDE_W-1:SIDE_W]));
  assign vec_z_in[0] = '0;

  gcd_cordic #(
    .STAGES (NST),
    .VECTOR (1'b1),
    .LANES  (1),
    .W      (CW),
    .SIDE_W (SIDE_W)
  ) u_vec (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq2_v),
    .in_x      (vec_x_in),
    .in_y      (vec_y_in),
    .in_z      (vec_z_in),
    .in_side   (sq2_side[SIDE_W-1:0]),
    .out_valid (vec_v),
    .out_x     (),
    .out_y     (),
    .out_z     (vec_z),
    .out_side  (vec_side)
  );

  // ---------------- stage 11: clamp half angle to a quarter turn
  logic               s11_v_r;
  logic [30:0]        s11_z_r;
  logic [SIDE_W-1:0]  s11_side_r;
  logic [30:0]        zc_nxt;

  always_comb begin
    if (vec_z[0][CW-1]) begin
      zc_nxt = '0;
    end else if (vec_z[0] > signed'(CW'(gcd_pkg::ONE_Q30))) begin
      zc_nxt = 31'(gcd_pkg::ONE_Q30);
    end else begin
      zc_nxt = vec_z[0][30:0];
    end
  end

  // ---------------- stage 12: full angle in radians q2.32
  logic               s12_v_r;
  logic [33:0]        s12_ang_r;
  logic [SIDE_W-1:0]  s12_side_r;
  logic [63:0]        ang_full;

  assign ang_full = 64'(s11_z_r) * (64'(gcd_pkg::TWO_PI_Q28) << 1) + (64'd1 << 27);

  // ---------------- stage 13: radius scaling partial products
  logic               s13_v_r;
  logic [49:0]        s13_a_r;
  logic [50:0]        s13_b_r;
  logic [33:0]        s13_ang_r;
  logic               s13_unit_r, s13_mism_r;

  // ---------------- output
  logic [34:0]        dist_full;
  logic [33:0]        dist_nxt;

  always_comb begin
    logic [50:0] acc;
    acc = 51'(s13_a_r) + (s13_b_r >> 16);
    if (s13_unit_r) begin
      dist_full = (35'(s13_ang_r) + 35'h8000) >> 16;
    end else begin
      dist_full = 35'(acc >> 16);
    end
    if (s13_mism_r) begin
      dist_nxt = '0;
    end else if (dist_full > 35'(gcd_pkg::DIST_MAX)) begin
      dist_nxt = gcd_pkg::DIST_MAX;
    end else begin
      dist_nxt = dist_full[33:0];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      s5_v_r      <= 1'b0;
      s6_v_r      <= 1'b0;
      s7_v_r      <= 1'b0;
      s8_v_r      <= 1'b0;
      s9_v_r      <= 1'b0;
      s10_v_r     <= 1'b0;
      s11_v_r     <= 1'b0;
      s12_v_r     <= 1'b0;
      s13_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_v_r      <= in_valid;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      s4_v_r      <= s3_v_r;
      s5_v_r      <= rot_v;
      s6_v_r      <= s5_v_r;
      s7_v_r      <= s6_v_r;
      s8_v_r      <= s7_v_r;
      s9_v_r      <= sq1_v;
      s10_v_r     <= s9_v_r;
      s11_v_r     <= vec_v;
      s12_v_r     <= s11_v_r;
      s13_v_r     <= s12_v_r;
      out_valid_r <= s13_v_r;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (en) begin
      s1_r1_r   <= in_first_radius;
      s1_r2_r   <= in_second_radius;
      s1_t1_r   <= in_first_theta;
      s1_p1_r   <= in_first_phi;
      s1_t2_r   <= in_second_theta;
      s1_p2_r   <= in_second_phi;
      s1_unit_r <= in_unit_sphere;

      s2_ang_r[0] <= 33'(s1_t1_r) - 33'(s1_t2_r);
      s2_ang_r[1] <= 33'(s1_p2_r) - 33'(s1_p1_r);
      s2_ang_r[2] <= 33'(s1_t1_r);
      s2_ang_r[3] <= 33'(s1_t2_r);
      s2_r1_r     <= s1_r1_r;
      s2_unit_r   <= s1_unit_r;
      s2_mism_r   <= mism_nxt;

      s3_ph_r   <= ph_nxt;
      s3_r1_r   <= s2_r1_r;
      s3_unit_r <= s2_unit_r;
      s3_mism_r <= s2_mism_r;

      s4_q_r    <= q_nxt;
      s4_z_r    <= z_nxt;
      s4_r1_r   <= s3_r1_r;
      s4_unit_r <= s3_unit_r;
      s4_mism_r <= s3_mism_r;

      s5_hvt_r  <= hv_nxt[0];
      s5_hvp_r  <= hv_nxt[1];
      s5_s1_r   <= 32'(sin_v[2]);
      s5_s2_r   <= 32'(sin_v[3]);
      s5_side_r <= rot_side[SIDE_W-1:0];

      s6_prod_r <= CW'(sprod >>> 30);
      s6_hvt_r  <= s5_hvt_r;
      s6_hvp_r  <= s5_hvp_r;
      s6_side_r <= s5_side_r;

      s7_m_r    <= CW'(mprod >>> 30);
      s7_hvt_r  <= s6_hvt_r;
      s7_side_r <= s6_side_r;

      s8_val_r  <= hval_nxt;
      s8_side_r <= s7_side_r;

      s9_sq_r   <= SQW'(sq1_root) * SQW'(sq1_root);
      s9_root_r <= sq1_root;
      s9_side_r <= sq1_side;

      s10_val_r  <= (SQW'(1) << 60) - s9_sq_r;
      s10_root_r <= s9_root_r;
      s10_side_r <= s9_side_r;

      s11_z_r    <= zc_nxt;
      s11_side_r <= vec_side;

      s12_ang_r  <= ang_full[61:28];
      s12_side_r <= s11_side_r;

      // side layout: radius, unit flag, mismatch flag
      s13_a_r    <= 50'(s12_ang_r) * 50'(s12_side_r[33:18]);
      s13_b_r    <= 51'(s12_ang_r) * 51'(s12_side_r[17:2]) + (51'd1 << 31);
      s13_ang_r  <= s12_ang_r;
      s13_unit_r <= s12_side_r[1];
      s13_mism_r <= s12_side_r[0];

      out_distance_r <= dist_nxt;
      out_mismatch_r <= s13_mism_r;
    end
  end

endmodule

>>> tb/great_circle_distance_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// great_circle_distance_test
// Drives point pairs into the haversine pipeline with random gaps on both
// sides and checks every distance and mismatch flag against a bit-exact
// predictor of the fixed-point datapath.
// ----------------------------------------------------------------------------

class distance_scoreboard;
  logic [33:0] exp_dist[$];
  logic        exp_mism[$];
  int          mismatches;
  int          checked;

  static function longint asr(longint v, int s);
    return v >>> s;
  endfunction

  static function longint sext32(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  static function logic [31:0] atan_of(int idx);
    longint t[32] = '{536870912, 316933406, 167458908, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1, 1, 0};
    return t[idx];
  endfunction

  static function logic [31:0] phase_of(longint a);
    longint p;
    logic [63:0] u;
    p = a * 64'sd683565276;
    u = 64'(p) + (64'd1 << (gcd_pkg::ANGLE_FRAC_BITS - 1));
    return u[gcd_pkg::ANGLE_FRAC_BITS +: 32];
  endfunction

  static function void rotate(logic [31:0] ph, output longint c, output longint s);
    logic [31:0] q, dif;
    longint z, x, y, nx, ny;
    int n;
    q = ((ph + 32'h2000_0000) >> 30) & 3;
    dif = ph - (q << 30);
    z = sext32(dif);
    x = 652032874;
    y = 0;
    n = gcd_pkg::CORDIC_STAGES > 32 ? 32 : gcd_pkg::CORDIC_STAGES;
    for (int i = 0; i < n; i++) begin
      if (z >= 0) begin
        nx = x - asr(y, i); ny = y + asr(x, i); z -= atan_of(i);
      end else begin
        nx = x + asr(y, i); ny = y - asr(x, i); z += atan_of(i);
      end
      x = nx; y = ny;
    end
    case (q)
      0: begin c = x; s = y; end
      1: begin c = -y; s = x; end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  static function longint arc_turns(longint x, longint y);
    longint z, nx, ny;
    int n;
    z = 0;
    n = gcd_pkg::CORDIC_STAGES > 32 ? 32 : gcd_pkg::CORDIC_STAGES;
    for (int i = 0; i < n; i++) begin
      if (y > 0) begin
        nx = x + asr(y, i); ny = y - asr(x, i); z += atan_of(i);
      end else begin
        nx = x - asr(y, i); ny = y + asr(x, i); z -= atan_of(i);
      end
      x = nx; y = ny;
    end
    if (z < 0) z = 0;
    if (z > (64'sd1 << 30)) z = 64'sd1 << 30;
    return z;
  endfunction

  static function logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  static function longint hav(longint a);
    longint c, s, hv;
    rotate(phase_of(a), c, s);
    hv = (64'sd1 << 30) - c;
    if (hv < 0) hv = 0;
    return hv >>> 1;
  endfunction

  function void note_input(logic [31:0] r1, logic [31:0] r2, logic [31:0] t1,
                           logic [31:0] p1, logic [31:0] t2, logic [31:0] p2,
                           logic unit);
    logic [63:0] d, root, co, ang, dist_v, a, b;
    longint ht, hp, c1, s1, c2, s2, prod, h, z;
    if (!unit) begin
      d = r1 > r2 ? 64'(r1 - r2) : 64'(r2 - r1);
      if (d * 100 > 64'(r1)) begin
        exp_dist.push_back('0);
        exp_mism.push_back(1'b1);
        return;
      end
    end
    ht = hav(sext32(t1) - sext32(t2));
    hp = hav(sext32(p2) - sext32(p1));
    rotate(phase_of(sext32(t1)), c1, s1);
    rotate(phase_of(sext32(t2)), c2, s2);
    prod = asr(s1 * s2, 30);
    h = ht + asr(prod * hp, 30);
    if (h < 0) h = 0;
    if (h > (64'sd1 << 30)) h = 64'sd1 << 30;
    root = floor_sqrt(64'(h) << 30);
    co = floor_sqrt((64'd1 << 60) - root * root);
    z = arc_turns(longint'(co), longint'(root));
    ang = (64'(z) * 2 * 64'd1686629713 + (64'd1 << 27)) >> 28;
    if (unit) begin
      dist_v = (ang + 64'h8000) >> 16;
    end else begin
      a = ang * 64'(r1[31:16]);
      b = ang * 64'(r1[15:0]) + (64'd1 << 31);
      dist_v = (a + (b >> 16)) >> 16;
    end
    if (dist_v > 64'h3_FFFF_FFFF) dist_v = 64'h3_FFFF_FFFF;
    exp_dist.push_back(dist_v[33:0]);
    exp_mism.push_back(1'b0);
  endfunction

  function void check_result(logic [33:0] got_dist, logic mism);
    logic [33:0] ed;
    logic em;
    checked++;
    if (exp_dist.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected item: dist %0d mism %0d", got_dist, mism);
      return;
    end
    ed = exp_dist.pop_front();
    em = exp_mism.pop_front();
    if (ed !== got_dist || em !== mism) begin
      mismatches++;
      if (mismatches <= 10)
        $display("item %0d: expected dist %0d mism %0d, got dist %0d mism %0d",
                 checked, ed, em, got_dist, mism);
    end
  endfunction
endclass

module great_circle_distance_test;
  localparam int NUM_RANDOM = 830;
  localparam int LATENCY = 76 + 2 * gcd_pkg::CORDIC_STAGES;
  localparam longint CYCLE_LIMIT = 400000;
  localparam logic [31:0] PI_Q28 = 32'd843314857;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [31:0] in_first_radius = '0;
  logic [31:0] in_second_radius = '0;
  logic signed [31:0] in_first_theta = '0;
  logic signed [31:0] in_first_phi = '0;
  logic signed [31:0] in_second_theta = '0;
  logic signed [31:0] in_second_phi = '0;
  logic in_unit_sphere = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [33:0] out_distance;
  logic out_radius_mismatch;

  distance_scoreboard sb = new();
  longint cycles = 0;
  int sent = 0;

  great_circle_distance u_dut (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("great_circle_distance test failed");
      $finish;
    end
  end

  // result side: random stall, sometimes long runs with no stall
  initial begin
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_result(out_distance, out_radius_mismatch);
    end
  end

  task automatic send_pair(logic [31:0] r1, logic [31:0] r2, logic [31:0] t1,
                           logic [31:0] p1, logic [31:0] t2, logic [31:0] p2,
                           logic unit, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_first_radius <= r1;
    in_second_radius <= r2;
    in_first_theta <= t1;
    in_first_phi <= p1;
    in_second_theta <= t2;
    in_second_phi <= p2;
    in_unit_sphere <= unit;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(r1, r2, t1, p1, t2, p2, unit);
    sent++;
  endtask

  function automatic int draw_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
  endfunction

  initial begin
    logic [31:0] r1, r2, t1, t2;
    int burst;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, antipodes, identical points, radius check edges
    send_pair('0, '0, '0, '0, '0, '0, 1'b0, 0);
    send_pair('0, 32'd1, '0, '0, PI_Q28, '0, 1'b0, 0);
    send_pair('1, '1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 0);
    send_pair('1, '0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 0);
    send_pair(32'h0001_0000, 32'h0001_0000, '0, '0, PI_Q28, '0, 1'b1, 0);
    send_pair(32'h0001_0000, 32'h0001_0000, PI_Q28 >> 1, '0, PI_Q28 >> 1, PI_Q28, 1'b0, 0);
    send_pair(32'd10000, 32'd10100, 32'd1000, 32'd2000, 32'd3000, 32'd4000, 1'b0, 1);
    send_pair(32'd10000, 32'd10101, 32'd1000, 32'd2000, 32'd3000, 32'd4000, 1'b0, 0);
    send_pair(32'd10000, 32'd9900, PI_Q28 >> 2, '0, PI_Q28 >> 2, '0, 1'b0, 0);
    send_pair(32'd10000, 32'd9899, PI_Q28 >> 2, '0, PI_Q28 >> 2, '0, 1'b0, 0);
    send_pair(32'd10000, 32'd20000, PI_Q28, PI_Q28, '0, '0, 1'b1, 0);
    send_pair('1, 32'hFD70_A3D7, PI_Q28 >> 1, '0, -(PI_Q28 >> 1), '0, 1'b0, 2);
    send_pair(32'h1234_5678, 32'h1234_5678, 32'd1, 32'd0, 32'd0, 32'd1, 1'b0, 0);
    send_pair(32'h0064_0000, 32'h0064_0000, PI_Q28 >> 1, 32'd5, PI_Q28 >> 1,
              PI_Q28 + 32'd5, 1'b0, 0);
    send_pair(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA,
              32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 0);

    // random: mostly matching radii so the full datapath is exercised
    while (sent < 15 + NUM_RANDOM) begin
      burst = $urandom_range(0, 7) == 0;
      r1 = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 32'h00FF_FFFF);
      case ($urandom_range(0, 9))
        0: r2 = $urandom();
        1: r2 = r1 + r1 / 100 + $urandom_range(0, 2);
        2: r2 = r1 - r1 / 100 - $urandom_range(0, 2);
        default: r2 = r1 + $urandom_range(0, r1 / 100) - r1 / 200;
      endcase
      t1 = ($urandom_range(0, 2) == 0) ? $urandom() : $urandom_range(0, PI_Q28);
      t2 = ($urandom_range(0, 2) == 0) ? $urandom() : $urandom_range(0, PI_Q28);
      send_pair(r1, r2, t1, $urandom(), t2, $urandom(), $urandom_range(0, 3) == 0,
                burst ? 0 : draw_gap());
    end
    in_valid <= 1'b0;

    while (sb.exp_dist.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);

    $display("sent %0d point pairs, checked %0d results, %0d mismatches",
             sent, sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("great_circle_distance test passed");
    end else begin
      $display("great_circle_distance test failed");
    end
    $finish;
  end
endmodule
